FILE: sv/pph_pkg.sv
package pph_pkg;

    // Fixed sizes of the request and result fields.
    localparam int COORD_INPUTS = 4;
    localparam int COORD_W      = 18;
    localparam int COUNT_W      = 32;
    localparam int DIMS_W       = 3;
    localparam int DIM_IDX_W    = $clog2(COORD_INPUTS);

    // Defaults of the top-level parameters.
    localparam int DEF_MAX_DIMS    = 4;
    localparam int DEF_PAIR_BINS   = 20;
    localparam int DEF_SINGLE_BINS = 100;

    // Widths that hold the largest legal parameter values, so the queue
    // entry has one layout for every configuration.
    localparam int SBIN_MAX_W  = 8;
    localparam int PBIN_MAX_W  = 6;
    localparam int SADDR_MAX_W = 11;
    localparam int PADDR_MAX_W = 17;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd4;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_PAIR   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // One classified request as it travels from the front to the back.
    // The pair bins are kept twice so that the row and the column each
    // have a select of their own.
    typedef struct packed {
        kind_t                                      kind;
        logic [DIMS_W-1:0]                          dims;
        logic [COORD_INPUTS-1:0][SBIN_MAX_W-1:0]    sbin;
        logic [COORD_INPUTS-1:0][PBIN_MAX_W-1:0]    prow;
        logic [COORD_INPUTS-1:0][PBIN_MAX_W-1:0]    pcol;
        logic [COORD_INPUTS-1:0]                    hi;
        logic [COORD_INPUTS-1:0]                    lo;
        logic                                       addr_ok;
        logic [SADDR_MAX_W-1:0]                     saddr;
        logic [PADDR_MAX_W-1:0]                     paddr;
    } pph_item_t;

endpackage

FILE: sv/pph_ram.sv
module pph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/pph_queue.sv
module pph_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pph_pkg::pph_item_t  push_item,
    input  logic                pop,
    output pph_pkg::pph_item_t  head,
    output logic                empty,
    output logic                full
);

    import pph_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pph_item_t          entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");
`endif

endmodule

FILE: sv/pph_front.sv
module pph_front #(
    parameter int MAX_DIMS    = pph_pkg::DEF_MAX_DIMS,
    parameter int PAIR_BINS   = pph_pkg::DEF_PAIR_BINS,
    parameter int SINGLE_BINS = pph_pkg::DEF_SINGLE_BINS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pph_pkg::DIMS_W-1:0]          active_dims,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          kind,
    input  logic signed [pph_pkg::COORD_W-1:0]  coord_0,
    input  logic signed [pph_pkg::COORD_W-1:0]  coord_1,
    input  logic signed [pph_pkg::COORD_W-1:0]  coord_2,
    input  logic signed [pph_pkg::COORD_W-1:0]  coord_3,
    input  logic [1:0]                          read_dim_a,
    input  logic [1:0]                          read_dim_b,
    input  logic [6:0]                          read_bin_a,
    input  logic [4:0]                          read_bin_b,
    input  logic                                q_full,
    input  logic                                clearing,
    output logic                                push,
    output pph_pkg::pph_item_t                  push_item
);

    import pph_pkg::*;

    localparam int DIM_CAP   = (MAX_DIMS < COORD_INPUTS) ? MAX_DIMS : COORD_INPUTS;
    localparam int PAIR_BANK = PAIR_BINS * PAIR_BINS;
    localparam int PROD_W    = 28;

    typedef struct packed {
        logic [SBIN_MAX_W-1:0] bin;
        logic                  hi;
        logic                  lo;
    } bin_res_t;

    // Scale a Q2.16 coordinate by the bin count, truncate toward zero and
    // clamp into the valid bin range.
    function automatic bin_res_t bin_of(input logic signed [COORD_W-1:0] c,
                                        input int nbins);
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W-1:0] neg;
        logic [PROD_W-17:0]       b;
        bin_res_t                 r;
        p   = PROD_W'(c) * PROD_W'(nbins);
        neg = -p;
        b   = p[PROD_W-1:16];
        r   = '0;
        if (!p[PROD_W-1])
        begin
            if (b >= (PROD_W-16)'(nbins))
            begin
                r.hi  = 1'b1;
                r.bin = SBIN_MAX_W'(nbins - 1);
            end
            else
            begin
                r.bin = b[SBIN_MAX_W-1:0];
            end
        end
        else
        begin
            // Small negative values truncate to zero and are not flagged.
            r.lo = |neg[PROD_W-1:16];
        end
        return r;
    endfunction

    // First bank number of the pairs whose higher dimension is a.
    function automatic logic [2:0] tri_base(input logic [1:0] a);
        logic [2:0] t;
        unique case (a)
            2'd0:    t = 3'd0;
            2'd1:    t = 3'd0;
            2'd2:    t = 3'd1;
            2'd3:    t = 3'd3;
            default: t = 3'd0;
        endcase
        return t;
    endfunction

    logic [DIMS_W-1:0]                      active_dims_reg;
    logic [DIMS_W-1:0]                      dims_eff;
    logic signed [COORD_W-1:0]              coord [COORD_INPUTS];
    logic                                   pair_used;
    bin_res_t                               sres [COORD_INPUTS];
    bin_res_t                               pres [COORD_INPUTS];
    kind_t                                  kind_in;
    logic [2:0]                             bank;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_dims_reg <= DIMS_RESET;
        end
        else if (cfg_valid)
        begin
            active_dims_reg <= active_dims;
        end
    end

    always_comb
    begin
        if (active_dims_reg == '0)
        begin
            dims_eff = DIMS_W'(1);
        end
        else if (active_dims_reg > DIMS_W'(DIM_CAP))
        begin
            dims_eff = DIMS_W'(DIM_CAP);
        end
        else
        begin
            dims_eff = active_dims_reg;
        end
    end

    assign coord[0]  = coord_0;
    assign coord[1]  = coord_1;
    assign coord[2]  = coord_2;
    assign coord[3]  = coord_3;
    assign pair_used = (dims_eff >= DIMS_W'(2));
    assign kind_in   = kind_t'(kind);
    assign bank      = tri_base(read_dim_a) + 3'(read_dim_b);

    assign in_ready = !q_full && !clearing;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        push_item      = '0;
        push_item.kind = kind_in;
        push_item.dims = dims_eff;
        for (int i = 0; i < COORD_INPUTS; i++)
        begin
            sres[i] = bin_of(coord[i], SINGLE_BINS);
            pres[i] = bin_of(coord[i], PAIR_BINS);
            push_item.sbin[i] = sres[i].bin;
            push_item.prow[i] = pres[i].bin[PBIN_MAX_W-1:0];
            push_item.pcol[i] = pres[i].bin[PBIN_MAX_W-1:0];
            if (DIMS_W'(i) < dims_eff)
            begin
                push_item.hi[i] = sres[i].hi || (pair_used && pres[i].hi);
                push_item.lo[i] = sres[i].lo || (pair_used && pres[i].lo);
            end
        end
        unique case (kind_in)
            KIND_SINGLE:
            begin
                push_item.addr_ok = (int'(read_dim_a) < MAX_DIMS)
                                 && (int'(read_bin_a) < SINGLE_BINS);
            end
            KIND_PAIR:
            begin
                push_item.addr_ok = (int'(read_dim_a) < MAX_DIMS)
                                 && (read_dim_a > read_dim_b)
                                 && (int'(read_bin_a) < PAIR_BINS)
                                 && (int'(read_bin_b) < PAIR_BINS);
            end
            KIND_ADD, KIND_NONE:
            begin
                push_item.addr_ok = 1'b0;
            end
            default:
            begin
                push_item.addr_ok = 1'b0;
            end
        endcase
        push_item.saddr = SADDR_MAX_W'(32'(read_dim_a) * SINGLE_BINS + 32'(read_bin_a));
        push_item.paddr = PADDR_MAX_W'(32'(bank) * PAIR_BANK + 32'(read_bin_a) * PAIR_BINS
                                       + 32'(read_bin_b));
    end

endmodule

FILE: sv/pph_back.sv
module pph_back #(
    parameter int MAX_DIMS    = pph_pkg::DEF_MAX_DIMS,
    parameter int PAIR_BINS   = pph_pkg::DEF_PAIR_BINS,
    parameter int SINGLE_BINS = pph_pkg::DEF_SINGLE_BINS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pph_pkg::pph_item_t              head,
    input  logic                            q_empty,
    output logic                            pop,
    output logic                            clearing,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pph_pkg::COUNT_W-1:0]     bin_count,
    output logic [pph_pkg::COORD_INPUTS-1:0] clamped_high,
    output logic [pph_pkg::COORD_INPUTS-1:0] clamped_low
);

    import pph_pkg::*;

    localparam int NUM_PAIRS    = (MAX_DIMS * (MAX_DIMS - 1)) / 2;
    localparam int PAIR_BANK    = PAIR_BINS * PAIR_BINS;
    localparam int PAIR_DEPTH   = NUM_PAIRS * PAIR_BANK;
    localparam int SINGLE_DEPTH = MAX_DIMS * SINGLE_BINS;
    localparam int CLEAR_LEN    = (PAIR_DEPTH > SINGLE_DEPTH) ? PAIR_DEPTH : SINGLE_DEPTH;
    localparam int SA_W         = $clog2(SINGLE_DEPTH);
    localparam int PA_W         = $clog2(PAIR_DEPTH);
    localparam int SB_W         = $clog2(SINGLE_BINS);
    localparam int PB_W         = $clog2(PAIR_BINS);
    localparam int CLR_W        = $clog2(CLEAR_LEN + 1);

    localparam logic [PA_W-1:0] PAIR_BINS_A   = PA_W'(PAIR_BINS);
    localparam logic [PA_W-1:0] PAIR_BANK_A   = PA_W'(PAIR_BANK);
    localparam logic [SA_W-1:0] SINGLE_BINS_A = SA_W'(SINGLE_BINS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_FETCH,
        ST_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [CLR_W-1:0]           clr_reg, clr_next;
    logic [DIM_IDX_W-1:0]       d_reg, d_next;
    logic [DIM_IDX_W-1:0]       e_reg, e_next;
    logic [SA_W-1:0]            sbase_reg, sbase_next;
    logic [PA_W-1:0]            pbase_reg, pbase_next;
    logic [COUNT_W-1:0]         res_count_reg, res_count_next;
    logic [COORD_INPUTS-1:0]    res_hi_reg, res_hi_next;
    logic [COORD_INPUTS-1:0]    res_lo_reg, res_lo_next;
    logic                       out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]         bin_count_reg, bin_count_next;
    logic [COORD_INPUTS-1:0]    clamped_high_reg, clamped_high_next;
    logic [COORD_INPUTS-1:0]    clamped_low_reg, clamped_low_next;

    logic [SA_W-1:0]            s_step;
    logic [PA_W-1:0]            p_step;
    logic                       single_step;
    logic                       pair_step;
    logic                       s_we, p_we;
    logic [SA_W-1:0]            s_waddr, s_raddr;
    logic [PA_W-1:0]            p_waddr, p_raddr;
    logic [COUNT_W-1:0]         s_wdata, p_wdata;
    logic [COUNT_W-1:0]         s_rdata, p_rdata;

    // Counter address of the current update step.
    assign s_step = sbase_reg + SA_W'(head.sbin[d_reg][SB_W-1:0]);
    assign p_step = pbase_reg + PA_W'(head.prow[d_reg][PB_W-1:0]) * PAIR_BINS_A
                  + PA_W'(head.pcol[e_reg][PB_W-1:0]);

    // The single counter of dimension d is bumped on the first step of d,
    // a pair counter on every step with e below d.
    assign single_step = (e_reg == '0);
    assign pair_step   = (e_reg < d_reg);

    assign clearing = (state_reg == ST_CLEAR);

    always_comb
    begin
        s_raddr = (state_reg == ST_IDLE) ? head.saddr[SA_W-1:0] : s_step;
        p_raddr = (state_reg == ST_IDLE) ? head.paddr[PA_W-1:0] : p_step;
        if (clearing)
        begin
            s_we    = (clr_reg < CLR_W'(SINGLE_DEPTH));
            p_we    = (clr_reg < CLR_W'(PAIR_DEPTH));
            s_waddr = clr_reg[SA_W-1:0];
            p_waddr = clr_reg[PA_W-1:0];
            s_wdata = '0;
            p_wdata = '0;
        end
        else
        begin
            s_we    = (state_reg == ST_WRITE) && single_step;
            p_we    = (state_reg == ST_WRITE) && pair_step;
            s_waddr = s_step;
            p_waddr = p_step;
            s_wdata = (s_rdata == '1) ? s_rdata : s_rdata + 1'b1;
            p_wdata = (p_rdata == '1) ? p_rdata : p_rdata + 1'b1;
        end
    end

    pph_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (SINGLE_DEPTH)
    ) u_single_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    pph_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (PAIR_DEPTH)
    ) u_pair_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    always_comb
    begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        d_next            = d_reg;
        e_next            = e_reg;
        sbase_next        = sbase_reg;
        pbase_next        = pbase_reg;
        res_count_next    = res_count_reg;
        res_hi_next       = res_hi_reg;
        res_lo_next       = res_lo_reg;
        out_valid_next    = out_valid_reg;
        bin_count_next    = bin_count_reg;
        clamped_high_next = clamped_high_reg;
        clamped_low_next  = clamped_low_reg;
        pop               = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(CLEAR_LEN - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (head.kind == KIND_ADD)
                    begin
                        d_next     = '0;
                        e_next     = '0;
                        sbase_next = '0;
                        pbase_next = '0;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (pair_step)
                begin
                    pbase_next = pbase_reg + PAIR_BANK_A;
                end
                if ((DIMS_W'(e_reg) + 1'b1) < DIMS_W'(d_reg))
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_READ;
                end
                else if ((DIMS_W'(d_reg) + 1'b1) < head.dims)
                begin
                    d_next     = d_reg + 1'b1;
                    e_next     = '0;
                    sbase_next = sbase_reg + SINGLE_BINS_A;
                    state_next = ST_READ;
                end
                else
                begin
                    res_count_next = '0;
                    res_hi_next    = head.hi;
                    res_lo_next    = head.lo;
                    state_next     = ST_DONE;
                end
            end
            ST_FETCH:
            begin
                if (!head.addr_ok)
                begin
                    res_count_next = '0;
                end
                else if (head.kind == KIND_PAIR)
                begin
                    res_count_next = p_rdata;
                end
                else
                begin
                    res_count_next = s_rdata;
                end
                res_hi_next = '0;
                res_lo_next = '0;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    bin_count_next    = res_count_reg;
                    clamped_high_next = res_hi_reg;
                    clamped_low_next  = res_lo_reg;
                    pop               = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            d_reg            <= '0;
            e_reg            <= '0;
            sbase_reg        <= '0;
            pbase_reg        <= '0;
            res_count_reg    <= '0;
            res_hi_reg       <= '0;
            res_lo_reg       <= '0;
            out_valid_reg    <= 1'b0;
            bin_count_reg    <= '0;
            clamped_high_reg <= '0;
            clamped_low_reg  <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            d_reg            <= d_next;
            e_reg            <= e_next;
            sbase_reg        <= sbase_next;
            pbase_reg        <= pbase_next;
            res_count_reg    <= res_count_next;
            res_hi_reg       <= res_hi_next;
            res_lo_reg       <= res_lo_next;
            out_valid_reg    <= out_valid_next;
            bin_count_reg    <= bin_count_next;
            clamped_high_reg <= clamped_high_next;
            clamped_low_reg  <= clamped_low_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign bin_count    = bin_count_reg;
    assign clamped_high = clamped_high_reg;
    assign clamped_low  = clamped_low_reg;

`ifndef ASSERT_OFF
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result presented without a finished request");

    a_add_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && head.kind == KIND_ADD) |-> (res_count_reg == '0))
        else $error("add request carries a nonzero count");
`endif

endmodule

FILE: sv/pairwise_projection_histogram_top.sv
// The back serves requests one at a time; an add request with n active dimensions
// takes S read-modify-write steps, S = 1 + sum over d = 1..n-1 of d, each step reading
// and writing back a counter through the two counter RAMs. The queue lets the front
// keep accepting requests while the back is busy, until the queue is full.
// Reset: asynchronous, active low; afterwards a clearing pass over max(pair depth,
// single depth) addresses (2400 by default) zeroes the counters while in_ready stays low.
module pairwise_projection_histogram_top #(
    parameter int MAX_DIMS    = pph_pkg::DEF_MAX_DIMS,
    parameter int PAIR_BINS   = pph_pkg::DEF_PAIR_BINS,
    parameter int SINGLE_BINS = pph_pkg::DEF_SINGLE_BINS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pph_pkg::DIMS_W-1:0]          active_dims,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          kind,
    input  logic signed [pph_pkg::COORD_W-1:0]  coord_0,
    input  logic signed [pph_pkg::COORD_W-1:0]  coord_1,
    input  logic signed [pph_pkg::COORD_W-1:0]  coord_2,
    input  logic signed [pph_pkg::COORD_W-1:0]  coord_3,
    input  logic [1:0]                          read_dim_a,
    input  logic [1:0]                          read_dim_b,
    input  logic [6:0]                          read_bin_a,
    input  logic [4:0]                          read_bin_b,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pph_pkg::COUNT_W-1:0]         bin_count,
    output logic [pph_pkg::COORD_INPUTS-1:0]    clamped_high,
    output logic [pph_pkg::COORD_INPUTS-1:0]    clamped_low
);

    import pph_pkg::*;

    // The front classifies each request in the cycle it is accepted: it bins
    // every coordinate for both histograms, collects the clamp flags of the
    // active dimensions and forms the counter address of a read request. The
    // classified request waits in a short queue, so the front keeps taking
    // requests while the back is busy.
    //
    // The back drains the queue one request at a time. An add request walks
    // the dimensions in order; for dimension d it steps e from 0 up to d-1,
    // and each step reads a counter and writes it back incremented with
    // saturation in the next cycle. The first step of each dimension also bumps
    // that dimension's single-axis counter. Because the steps go in the same
    // order as the pair bank numbers, the pair bank base simply advances by
    // one bank per pair step. A read request reads both RAMs at once and keeps
    // the word that matches its kind, or zero for a bad address.
    //
    // The result goes to an output register, so the back can start on the
    // next queued request while a finished result still waits on out_ready.

    pph_item_t  push_item;
    pph_item_t  head_item;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    logic       clearing;

    pph_front #(
        .MAX_DIMS    (MAX_DIMS),
        .PAIR_BINS   (PAIR_BINS),
        .SINGLE_BINS (SINGLE_BINS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .active_dims (active_dims),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .coord_0     (coord_0),
        .coord_1     (coord_1),
        .coord_2     (coord_2),
        .coord_3     (coord_3),
        .read_dim_a  (read_dim_a),
        .read_dim_b  (read_dim_b),
        .read_bin_a  (read_bin_a),
        .read_bin_b  (read_bin_b),
        .q_full      (q_full),
        .clearing    (clearing),
        .push        (push),
        .push_item   (push_item)
    );

    pph_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    pph_back #(
        .MAX_DIMS    (MAX_DIMS),
        .PAIR_BINS   (PAIR_BINS),
        .SINGLE_BINS (SINGLE_BINS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_item),
        .q_empty      (q_empty),
        .pop          (pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bin_count    (bin_count),
        .clamped_high (clamped_high),
        .clamped_low  (clamped_low)
    );

endmodule
